// File: sv/rhs_pkg.sv
package rhs_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int GATE_W  = 31;
    localparam int RES_W   = 32;
    localparam int MAG_W   = 32;
    localparam int LIMIT_W = 16;
    localparam int RUN_W   = 16;
    localparam int SCORE_W = 17;
    localparam int QUOT_W  = 18;
    localparam int SUM_W   = 24;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 2;
    localparam int RECIP_W = 25;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] EV_CONTINUITY = 2'd0;
    localparam logic [KIND_W-1:0] EV_SWITCH     = 2'd1;

    localparam logic [INDEX_W-1:0] REG_YAW_GATE    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_Z_GATE      = 2'd1;
    localparam logic [INDEX_W-1:0] REG_PLANAR_GATE = 2'd2;
    localparam logic [INDEX_W-1:0] REG_RUN_LIMIT   = 2'd3;

    localparam logic [GATE_W-1:0]  YAW_GATE_RST    = 31'd19661;
    localparam logic [GATE_W-1:0]  Z_GATE_RST      = 31'd3277;
    localparam logic [GATE_W-1:0]  PLANAR_GATE_RST = 31'd6554;
    localparam logic [LIMIT_W-1:0] RUN_LIMIT_RST   = 16'd5;

    localparam logic [QUOT_W-1:0]  TERM_MAX      = 18'd131072;
    localparam logic [QUOT_W-1:0]  PEN_ONE       = 18'd65536;
    localparam logic [SCORE_W-1:0] SCORE_ONE     = 17'd65536;
    localparam logic [SCORE_W-1:0] BAD_SCORE_MAX = 17'd19660;

    // floor(x / 100) and floor(x / 75) as (x * recip) >> 31, exact for x < 2^24
    localparam int                PEN_SHIFT     = 31;
    localparam logic [RECIP_W-1:0] PEN_RECIP_Z   = 25'd21474837;
    localparam logic [RECIP_W-1:0] PEN_RECIP_NOZ = 25'd28633116;
    localparam logic [SUM_W-1:0]  PEN_BIAS_Z   = 24'd99;
    localparam logic [SUM_W-1:0]  PEN_BIAS_NOZ = 24'd74;
    localparam logic [SUM_W-1:0]  W_YAW        = 24'd40;
    localparam logic [SUM_W-1:0]  W_REST       = 24'd35;

    typedef struct packed {
        logic [MAG_W-1:0] yaw_mag;
        logic [MAG_W-1:0] z_mag;
        logic [MAG_W-1:0] planar_mag;
        logic             z_valid;
        logic             scorable;
    } rhs_item_t;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  hi;
        logic [QUOT_W-1:0] lo;
        logic [GATE_W-1:0] divisor;
    } rhs_div_req_t;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [QUOT_W-1:0] quot;
    } rhs_div_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_START,
        BK_WAIT,
        BK_SUM,
        BK_PEN,
        BK_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        TS_YAW,
        TS_Z,
        TS_PLANAR
    } term_sel_t;

    function automatic logic [GATE_W-1:0] floor_gate(
        input logic [GATE_W-1:0] gate,
        input logic [GATE_W-1:0] floor_val
    );
        return (gate < floor_val) ? floor_val : gate;
    endfunction

endpackage

// File: sv/rhs_front.sv
module rhs_front
(
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rhs_pkg::KIND_W-1:0]    event_kind,
    input  logic                          yaw_finite,
    input  logic signed [rhs_pkg::RES_W-1:0] yaw_error,
    input  logic                          z_jump_present,
    input  logic                          z_jump_finite,
    input  logic signed [rhs_pkg::RES_W-1:0] z_jump,
    input  logic                          planar_finite,
    input  logic signed [rhs_pkg::RES_W-1:0] planar_residual,
    input  logic [rhs_pkg::GATE_W-1:0]    yaw_norm_fl,
    input  logic                          q_full,
    output logic                          q_push,
    output rhs_pkg::rhs_item_t            q_item
);
    import rhs_pkg::*;

    logic             z_valid;
    logic [MAG_W-1:0] z_abs;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign z_valid = (event_kind == EV_CONTINUITY) && z_jump_present && z_jump_finite;
    assign z_abs   = z_jump[RES_W-1] ? (MAG_W'(0) - MAG_W'(z_jump)) : MAG_W'(z_jump);

    always_comb
    begin
        if (!yaw_finite)
            q_item.yaw_mag = MAG_W'(yaw_norm_fl);
        else if (yaw_error[RES_W-1])
            q_item.yaw_mag = '0;
        else
            q_item.yaw_mag = MAG_W'(yaw_error);

        if (planar_finite && !planar_residual[RES_W-1])
            q_item.planar_mag = MAG_W'(planar_residual);
        else
            q_item.planar_mag = '0;

        q_item.z_mag    = z_valid ? z_abs : '0;
        q_item.z_valid  = z_valid;
        q_item.scorable = (event_kind == EV_CONTINUITY) || (event_kind == EV_SWITCH);
    end

endmodule

// File: sv/rhs_queue.sv
module rhs_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rhs_pkg::rhs_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output rhs_pkg::rhs_item_t pop_item
);
    import rhs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rhs_item_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// File: sv/rhs_div.sv
module rhs_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rhs_pkg::rhs_div_req_t req,
    output rhs_pkg::rhs_div_rsp_t rsp
);
    import rhs_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              sat_reg;
    logic              sat_next;
    logic [GATE_W-1:0] rem_reg;
    logic [GATE_W-1:0] rem_next;
    logic [QUOT_W-1:0] lo_reg;
    logic [QUOT_W-1:0] lo_next;
    logic [QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0] quot_next;

    logic [GATE_W:0]   trial;
    logic [GATE_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, lo_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, req.divisor};
    assign fits  = (trial >= {1'b0, req.divisor});

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quot = quot_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        sat_next  = sat_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            if (req.hi >= MAG_W'(req.divisor))
            begin
                sat_next  = 1'b1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                sat_next  = 1'b0;
                busy_next = 1'b1;
                step_next = '0;
                rem_next  = req.hi[GATE_W-1:0];
                lo_next   = req.lo;
                quot_next = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[GATE_W-1:0] : trial[GATE_W-1:0];
            lo_next   = {lo_reg[QUOT_W-2:0], 1'b0};
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            if (step_reg == STEP_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        quot_reg <= quot_next;
    end

endmodule

// File: sv/rhs_back.sv
module rhs_back
#(
    parameter int COUNT_WIDTH = rhs_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  rhs_pkg::rhs_item_t             q_item,
    output logic                           q_pop,
    input  logic [rhs_pkg::GATE_W-1:0]     yaw_norm_fl,
    input  logic [rhs_pkg::GATE_W-1:0]     z_gate_fl,
    input  logic [rhs_pkg::GATE_W-1:0]     planar_gate_fl,
    input  logic [rhs_pkg::LIMIT_W-1:0]    run_limit,
    output rhs_pkg::rhs_div_req_t          div_req,
    input  rhs_pkg::rhs_div_rsp_t          div_rsp,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rhs_pkg::SCORE_W-1:0]    health_score,
    output logic                           anomaly,
    output logic [rhs_pkg::RUN_W-1:0]      bad_run,
    output logic                           rebind_advice
);
    import rhs_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > RUN_W) ? COUNT_WIDTH : RUN_W;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    back_state_t       state_reg;
    back_state_t       state_next;
    term_sel_t         sel_reg;
    term_sel_t         sel_next;
    rhs_item_t         item_reg;
    rhs_item_t         item_next;
    logic [QUOT_W-1:0] yaw_t_reg;
    logic [QUOT_W-1:0] yaw_t_next;
    logic [QUOT_W-1:0] z_t_reg;
    logic [QUOT_W-1:0] z_t_next;
    logic [QUOT_W-1:0] planar_t_reg;
    logic [QUOT_W-1:0] planar_t_next;
    logic [SUM_W-1:0]  numer_reg;
    logic [SUM_W-1:0]  numer_next;
    logic [QUOT_W-1:0] pen_reg;
    logic [QUOT_W-1:0] pen_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic              anomaly_reg;
    logic              anomaly_next;
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;
    logic              advice_reg;
    logic              advice_next;

    logic [MAG_W-1:0]  sel_mag;
    logic [GATE_W-1:0] sel_gate;
    logic [QUOT_W-1:0] term_val;
    logic [SUM_W-1:0]  sum;
    logic [RECIP_W-1:0] pen_recip;
    logic [PROD_W-1:0] pen_prod;
    logic [SCORE_W-1:0] score;
    logic              bad;
    logic [COUNT_WIDTH-1:0] count_upd;
    logic [EXT_W-1:0]  count_ext;

    assign out_valid     = out_valid_reg;
    assign health_score  = score_reg;
    assign anomaly       = anomaly_reg;
    assign bad_run       = run_reg;
    assign rebind_advice = advice_reg;

    always_comb
    begin
        unique case (sel_reg)
            TS_YAW:
            begin
                sel_mag  = item_reg.yaw_mag;
                sel_gate = yaw_norm_fl;
            end
            TS_Z:
            begin
                sel_mag  = item_reg.z_mag;
                sel_gate = z_gate_fl;
            end
            TS_PLANAR:
            begin
                sel_mag  = item_reg.planar_mag;
                sel_gate = planar_gate_fl;
            end
            default:
            begin
                sel_mag  = '0;
                sel_gate = yaw_norm_fl;
            end
        endcase
    end

    assign term_val = (div_rsp.sat || (div_rsp.quot > TERM_MAX)) ? TERM_MAX : div_rsp.quot;
    assign sum = SUM_W'(yaw_t_reg) * W_YAW
               + (SUM_W'(z_t_reg) + SUM_W'(planar_t_reg)) * W_REST;
    assign pen_recip = item_reg.z_valid ? PEN_RECIP_Z : PEN_RECIP_NOZ;
    assign pen_prod  = PROD_W'(numer_reg) * PROD_W'(pen_recip);
    assign score = (pen_reg >= PEN_ONE) ? '0 : SCORE_ONE - SCORE_W'(pen_reg);
    assign bad = item_reg.scorable && (score <= BAD_SCORE_MAX);
    assign count_upd = bad ? ((count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1) : '0;
    assign count_ext = EXT_W'(count_upd);

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        item_next      = item_reg;
        yaw_t_next     = yaw_t_reg;
        z_t_next       = z_t_reg;
        planar_t_next  = planar_t_reg;
        numer_next     = numer_reg;
        pen_next       = pen_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        score_next     = score_reg;
        anomaly_next   = anomaly_reg;
        run_next       = run_reg;
        advice_next    = advice_reg;
        q_pop          = 1'b0;
        div_req.start   = 1'b0;
        div_req.hi      = {2'b00, sel_mag[MAG_W-1:2]};
        div_req.lo      = {sel_mag[1:0], {(QUOT_W - 2){1'b0}}};
        div_req.divisor = sel_gate;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    sel_next   = TS_YAW;
                    state_next = BK_START;
                end
            end
            BK_START:
            begin
                div_req.start = 1'b1;
                state_next    = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (div_rsp.done)
                begin
                    unique case (sel_reg)
                        TS_YAW:
                        begin
                            yaw_t_next = term_val;
                            sel_next   = TS_Z;
                            state_next = BK_START;
                        end
                        TS_Z:
                        begin
                            z_t_next   = term_val;
                            sel_next   = TS_PLANAR;
                            state_next = BK_START;
                        end
                        TS_PLANAR:
                        begin
                            planar_t_next = term_val;
                            state_next    = BK_SUM;
                        end
                        default:
                        begin
                            state_next = BK_SUM;
                        end
                    endcase
                end
            end
            BK_SUM:
            begin
                numer_next = sum + (item_reg.z_valid ? PEN_BIAS_Z : PEN_BIAS_NOZ);
                state_next = BK_PEN;
            end
            BK_PEN:
            begin
                pen_next   = pen_prod[PEN_SHIFT +: QUOT_W];
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    score_next     = score;
                    anomaly_next   = bad;
                    count_next     = count_upd;
                    run_next       = count_ext[RUN_W-1:0];
                    advice_next    = (count_ext >= EXT_W'(run_limit));
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            sel_reg       <= TS_YAW;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        yaw_t_reg    <= yaw_t_next;
        z_t_reg      <= z_t_next;
        planar_t_reg <= planar_t_next;
        numer_reg    <= numer_next;
        pen_reg      <= pen_next;
        score_reg    <= score_next;
        anomaly_reg  <= anomaly_next;
        run_reg      <= run_next;
        advice_reg   <= advice_next;
    end

endmodule

// File: sv/residual_health_scorer_core.sv
// Scores tracking binding health once per frame: each residual is divided by its gate
// (floored at 0.001), clamped to 2.0, weighted, and the penalty taken from 1.0 gives a
// Q1.16 score; continuity and switch-candidate frames scoring below 0.3 extend a saturating
// bad-frame run that is compared with the run limit. Each frame is popped from the queue,
// then takes three passes through one shared divider that retires one quotient bit per
// cycle; the back end then forms the weighted sum, scales the penalty by a reciprocal
// multiply and registers the result. A ratio that saturates ends its pass without the
// bit-serial steps. A two-beat queue holds accepted frames ahead of the divider, and one
// result register lets the next frame proceed while a finished result waits on out_stall.
module residual_health_scorer_core
#(
    parameter int FRAC_BITS   = rhs_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = rhs_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rhs_pkg::INDEX_W-1:0]      cfg_index,
    input  logic [rhs_pkg::GATE_W-1:0]       cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rhs_pkg::KIND_W-1:0]       event_kind,
    input  logic                             yaw_finite,
    input  logic signed [rhs_pkg::RES_W-1:0] yaw_error,
    input  logic                             z_jump_present,
    input  logic                             z_jump_finite,
    input  logic signed [rhs_pkg::RES_W-1:0] z_jump,
    input  logic                             planar_finite,
    input  logic signed [rhs_pkg::RES_W-1:0] planar_residual,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rhs_pkg::SCORE_W-1:0]      health_score,
    output logic                             anomaly,
    output logic [rhs_pkg::RUN_W-1:0]        bad_run,
    output logic                             rebind_advice
);
    import rhs_pkg::*;

    localparam int FLOOR_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam logic [GATE_W-1:0] GATE_FLOOR = GATE_W'((FLOOR_RAW == 0) ? 1 : FLOOR_RAW);

    logic [GATE_W-1:0]  yaw_norm_reg;
    logic [GATE_W-1:0]  z_gate_reg;
    logic [GATE_W-1:0]  planar_gate_reg;
    logic [LIMIT_W-1:0] run_limit_reg;
    logic [GATE_W-1:0]  yaw_norm_fl;
    logic [GATE_W-1:0]  z_gate_fl;
    logic [GATE_W-1:0]  planar_gate_fl;

    logic         q_full;
    logic         q_push;
    logic         q_pop;
    logic         q_valid;
    rhs_item_t    front_item;
    rhs_item_t    back_item;
    rhs_div_req_t div_req;
    rhs_div_rsp_t div_rsp;

    assign yaw_norm_fl    = floor_gate(yaw_norm_reg, GATE_FLOOR);
    assign z_gate_fl      = floor_gate(z_gate_reg, GATE_FLOOR);
    assign planar_gate_fl = floor_gate(planar_gate_reg, GATE_FLOOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_norm_reg    <= YAW_GATE_RST;
            z_gate_reg      <= Z_GATE_RST;
            planar_gate_reg <= PLANAR_GATE_RST;
            run_limit_reg   <= RUN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_YAW_GATE:    yaw_norm_reg    <= cfg_wdata;
                REG_Z_GATE:      z_gate_reg      <= cfg_wdata;
                REG_PLANAR_GATE: planar_gate_reg <= cfg_wdata;
                REG_RUN_LIMIT:   run_limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                default:         run_limit_reg   <= run_limit_reg;
            endcase
        end
    end

    rhs_front u_front
    (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .event_kind      (event_kind),
        .yaw_finite      (yaw_finite),
        .yaw_error       (yaw_error),
        .z_jump_present  (z_jump_present),
        .z_jump_finite   (z_jump_finite),
        .z_jump          (z_jump),
        .planar_finite   (planar_finite),
        .planar_residual (planar_residual),
        .yaw_norm_fl     (yaw_norm_fl),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (front_item)
    );

    rhs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (back_item)
    );

    rhs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rhs_back
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (back_item),
        .q_pop          (q_pop),
        .yaw_norm_fl    (yaw_norm_fl),
        .z_gate_fl      (z_gate_fl),
        .planar_gate_fl (planar_gate_fl),
        .run_limit      (run_limit_reg),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .health_score   (health_score),
        .anomaly        (anomaly),
        .bad_run        (bad_run),
        .rebind_advice  (rebind_advice)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && anomaly) |-> (health_score <= BAD_SCORE_MAX))
        else $error("bad frame with passing score");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !anomaly) |-> (bad_run == '0))
        else $error("bad run not cleared on good frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (health_score > SCORE_ONE)) |-> 1'b0)
        else $error("score above one");

endmodule
